// ===== sv/pfe_pkg.sv =====
// Shared types, character codes and status codes of the postfix expression evaluator.
package pfe_pkg;

  // Data word of the operand stack and of the result.
  localparam int WORD_W = 32;

  // Default number of stack entries.
  localparam int STACK_DEPTH = 16;

  // Character codes.
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_STAR    = 8'd42;
  localparam logic [7:0] CH_SLASH   = 8'd47;

  // Number base of the digit accumulation.
  localparam logic [WORD_W-1:0] RADIX = 32'd10;

  // Status codes of a result.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_DIVZERO   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // One request: a character and the end-of-expression flag.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } pfe_req_t;

  // One result: top of stack and status.
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic [2:0]               status;
  } pfe_res_t;

  // Keeps the first error of an expression.
  function automatic logic [2:0] first_err(input logic [2:0] cur, input logic [2:0] code);
    first_err = (cur == ST_OK) ? code : cur;
  endfunction

endpackage

// ===== sv/pfe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pfe_div.sv =====
// Serial signed divider: one quotient bit per cycle, truncating toward zero.
module pfe_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pfe_pkg::WORD_W-1:0] dividend,
  input  logic [pfe_pkg::WORD_W-1:0] divisor,
  output logic                      done,
  output logic [pfe_pkg::WORD_W-1:0] quotient
);

  localparam int W  = pfe_pkg::WORD_W;
  localparam int CW = $clog2(W);

  logic          run;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic          neg;
  logic [W:0]    trial;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;

  // Operand magnitudes at start.
  assign mag_a = dividend[W-1] ? (~dividend + W'(1)) : dividend;
  assign mag_b = divisor[W-1]  ? (~divisor + W'(1))  : divisor;

  // Trial subtraction of the shifted partial remainder.
  assign trial = {rem, quo[W-1]} - {1'b0, dvs};

  // Restore the sign of the quotient.
  assign quotient = neg ? (~quo + W'(1)) : quo;

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Data path of the restoring division.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag_a;
      dvs <= mag_b;
      rem <= '0;
      neg <= dividend[W-1] ^ divisor[W-1];
    end else if (run) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== sv/postfix_expression_evaluator_unit.sv =====
// Postfix evaluator: a digit or separator is taken in the idle state; + - * pass through the read
// state, as the left operand comes from the stack RAM with registered read data; / then waits in
// the divide state for the serial divider, but skips it when the divisor is zero; an operator
// that finds fewer than two values stays in the idle state. The character flagged last adds the
// finish state, in which the result is moved to the output register, and which holds while an
// earlier result still waits there. The top of stack is held in a register, the values below it
// in the stack RAM. No clearing pass is needed after reset.
module postfix_expression_evaluator_unit #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              chr_valid,
  output logic              chr_ready,
  input  pfe_pkg::pfe_req_t chr_data,
  output logic              res_valid,
  input  logic              res_ready,
  output pfe_pkg::pfe_res_t res_data
);

  localparam int W  = pfe_pkg::WORD_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_DIVIDE = 4'b0100,
    S_FINISH = 4'b1000
  } pfe_state_t;

  pfe_state_t        state, state_next;
  logic [W-1:0]      tos, tos_next;
  logic [CW-1:0]     count, count_next;
  logic              prev_dig, prev_dig_next;
  logic [2:0]        err, err_next;
  logic [7:0]        op, op_next;
  logic              last, last_next;
  logic              res_valid_next;
  pfe_pkg::pfe_res_t res_data_next;

  logic              ram_we;
  logic [W-1:0]      ram_rdata;
  logic [CW-1:0]     count_m1;
  logic [CW-1:0]     count_m2;
  logic [W-1:0]      digit;
  logic              div_start;
  logic              div_done;
  logic [W-1:0]      div_q;

  assign count_m1  = count - CW'(1);
  assign count_m2  = count - CW'(2);
  assign digit     = W'(chr_data.ch - pfe_pkg::ASCII_ZERO);
  assign chr_ready = (state == S_IDLE);

  // Entries below the top of stack.
  pfe_ram #(
    .WIDTH(W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_m1[AW-1:0]),
    .wdata(tos),
    .raddr(count_m2[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Divider shared by every division.
  pfe_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(ram_rdata),
    .divisor (tos),
    .done    (div_done),
    .quotient(div_q)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next     = state;
    tos_next       = tos;
    count_next     = count;
    prev_dig_next  = prev_dig;
    err_next       = err;
    op_next        = op;
    last_next      = last;
    ram_we         = 1'b0;
    div_start      = 1'b0;
    res_valid_next = res_valid && !res_ready;
    res_data_next  = res_data;

    case (state)
      S_IDLE: begin
        if (chr_valid) begin
          last_next  = chr_data.last;
          state_next = chr_data.last ? S_FINISH : S_IDLE;
          if (chr_data.ch inside {[pfe_pkg::ASCII_ZERO:pfe_pkg::CH_NINE]}) begin
            if (prev_dig && count != '0) begin
              // Extend the number on top of the stack.
              tos_next = tos * pfe_pkg::RADIX + digit;
            end else if (count == CW'(STACK_DEPTH)) begin
              err_next      = pfe_pkg::first_err(err, pfe_pkg::ST_FULL);
              prev_dig_next = 1'b0;
            end else begin
              // Push: the old top moves into the RAM.
              ram_we        = (count != '0);
              tos_next      = digit;
              count_next    = count + CW'(1);
              prev_dig_next = 1'b1;
            end
          end else if (chr_data.ch inside {pfe_pkg::CH_PLUS, pfe_pkg::CH_MINUS,
                                           pfe_pkg::CH_STAR, pfe_pkg::CH_SLASH}) begin
            prev_dig_next = 1'b0;
            if (count < CW'(2)) begin
              err_next = pfe_pkg::first_err(err, pfe_pkg::ST_UNDERFLOW);
            end else begin
              op_next    = chr_data.ch;
              state_next = S_READ;
            end
          end else begin
            prev_dig_next = 1'b0;
          end
        end
      end

      S_READ: begin
        // Left operand is now on the RAM read port; the right one is the top.
        count_next = count_m1;
        state_next = last ? S_FINISH : S_IDLE;
        case (op)
          pfe_pkg::CH_PLUS:  tos_next = ram_rdata + tos;
          pfe_pkg::CH_MINUS: tos_next = ram_rdata - tos;
          pfe_pkg::CH_STAR:  tos_next = ram_rdata * tos;
          default: begin
            if (tos == '0) begin
              err_next = pfe_pkg::first_err(err, pfe_pkg::ST_DIVZERO);
              tos_next = '0;
            end else begin
              div_start  = 1'b1;
              state_next = S_DIVIDE;
            end
          end
        endcase
      end

      S_DIVIDE: begin
        if (div_done) begin
          tos_next   = div_q;
          state_next = last ? S_FINISH : S_IDLE;
        end
      end

      S_FINISH: begin
        // Hand the result over once the output register is free, then clear.
        if (!res_valid || res_ready) begin
          res_valid_next       = 1'b1;
          res_data_next.value  = (count != '0) ? tos : '0;
          if (err != pfe_pkg::ST_OK) begin
            res_data_next.status = err;
          end else begin
            res_data_next.status = (count != '0) ? pfe_pkg::ST_OK : pfe_pkg::ST_EMPTY;
          end
          count_next    = '0;
          prev_dig_next = 1'b0;
          err_next      = pfe_pkg::ST_OK;
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      prev_dig  <= 1'b0;
      err       <= pfe_pkg::ST_OK;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      prev_dig  <= prev_dig_next;
      err       <= err_next;
      res_valid <= res_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tos      <= tos_next;
    op       <= op_next;
    last     <= last_next;
    res_data <= res_data_next;
  end

endmodule

// ===== sv/pfe_chk.sv =====
// Port checker of the postfix evaluator and its bind to the top level.
module pfe_chk (
  input logic              clk,
  input logic              rst,
  input logic              chr_valid,
  input logic              chr_ready,
  input pfe_pkg::pfe_req_t chr_data,
  input logic              res_valid,
  input logic              res_ready,
  input pfe_pkg::pfe_res_t res_data
);

  // A result that waits holds still.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.status <= pfe_pkg::ST_EMPTY)
    else $error("undefined status code");

  // An empty stack at the end reports zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status == pfe_pkg::ST_EMPTY |-> res_data.value == '0)
    else $error("empty result carries a value");

  // A digit or separator that does not end the expression leaves the input ready in the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    chr_valid && chr_ready && !chr_data.last &&
    !(chr_data.ch == pfe_pkg::CH_PLUS || chr_data.ch == pfe_pkg::CH_MINUS ||
      chr_data.ch == pfe_pkg::CH_STAR || chr_data.ch == pfe_pkg::CH_SLASH)
    |=> chr_ready)
    else $error("single-cycle request stalled the input");

endmodule

bind postfix_expression_evaluator_unit pfe_chk u_pfe_chk (.*);

// ===== sim/postfix_expression_evaluator_unit_tb.sv =====
// Self-checking testbench for the postfix expression evaluator: directed table, then random RPN.
`timescale 1ns / 100ps

module postfix_expression_evaluator_unit_tb;

  localparam int IDLE_PCT     = 17;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              chr_valid = 1'b0;
  logic              chr_ready;
  pfe_pkg::pfe_req_t chr_data = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  pfe_pkg::pfe_res_t res_data;

  postfix_expression_evaluator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr_data  (chr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the evaluator state.
  logic [pfe_pkg::WORD_W-1:0] shadow_stack [pfe_pkg::STACK_DEPTH];
  int unsigned                shadow_count = 0;
  bit                         shadow_chained = 1'b0;
  logic [2:0]                 shadow_err = pfe_pkg::ST_OK;

  // Results still owed by the block, oldest first.
  pfe_pkg::pfe_res_t due_results [$];
  int                fail_cnt = 0;
  int                sent_cnt = 0;
  bit                quiet = 1'b0;

  // One row of the directed table; the expected result is filled in only where obvious.
  typedef struct {
    pfe_pkg::pfe_req_t req;
    bit                typed;
    pfe_pkg::pfe_res_t res;
  } char_row_t;

  char_row_t   directed_rows [$];
  logic [7:0]  expr_chars [$];

  function automatic void note_error(input logic [2:0] code);
    if (shadow_err == pfe_pkg::ST_OK) shadow_err = code;
  endfunction

  // Applies one character to the shadow state; returns 1 and the result when it ends an
  // expression.
  function automatic bit rpn_apply_char(input pfe_pkg::pfe_req_t r,
                                        output pfe_pkg::pfe_res_t res);
    logic [pfe_pkg::WORD_W-1:0] digit;
    logic [pfe_pkg::WORD_W-1:0] lhs;
    logic [pfe_pkg::WORD_W-1:0] rhs;
    logic [pfe_pkg::WORD_W-1:0] acc;
    logic [pfe_pkg::WORD_W-1:0] mag_l;
    logic [pfe_pkg::WORD_W-1:0] mag_r;
    res = '0;
    if (r.ch >= pfe_pkg::ASCII_ZERO && r.ch <= pfe_pkg::CH_NINE) begin
      digit = pfe_pkg::WORD_W'(r.ch - pfe_pkg::ASCII_ZERO);
      if (shadow_chained && shadow_count > 0) begin
        shadow_stack[shadow_count-1] = shadow_stack[shadow_count-1] * pfe_pkg::RADIX + digit;
      end else if (shadow_count >= pfe_pkg::STACK_DEPTH) begin
        // A full stack drops the digit, and the next digit does not extend the top number.
        note_error(pfe_pkg::ST_FULL);
        shadow_chained = 1'b0;
      end else begin
        shadow_stack[shadow_count] = digit;
        shadow_count++;
        shadow_chained = 1'b1;
      end
    end else if (r.ch inside {pfe_pkg::CH_PLUS, pfe_pkg::CH_MINUS,
                              pfe_pkg::CH_STAR, pfe_pkg::CH_SLASH}) begin
      shadow_chained = 1'b0;
      if (shadow_count < 2) begin
        note_error(pfe_pkg::ST_UNDERFLOW);
      end else begin
        rhs = shadow_stack[shadow_count-1];
        lhs = shadow_stack[shadow_count-2];
        shadow_count -= 2;
        case (r.ch)
          pfe_pkg::CH_PLUS:  acc = lhs + rhs;
          pfe_pkg::CH_MINUS: acc = lhs - rhs;
          pfe_pkg::CH_STAR:  acc = lhs * rhs;
          default: begin
            // Division truncates toward zero; the most negative value over -1 wraps.
            if (rhs == '0) begin
              note_error(pfe_pkg::ST_DIVZERO);
              acc = '0;
            end else begin
              mag_l = lhs[pfe_pkg::WORD_W-1] ? -lhs : lhs;
              mag_r = rhs[pfe_pkg::WORD_W-1] ? -rhs : rhs;
              acc = mag_l / mag_r;
              if (lhs[pfe_pkg::WORD_W-1] ^ rhs[pfe_pkg::WORD_W-1]) acc = -acc;
            end
          end
        endcase
        shadow_stack[shadow_count] = acc;
        shadow_count++;
      end
    end else begin
      shadow_chained = 1'b0;
    end

    if (!r.last) return 1'b0;

    // End of expression: report the top, then clear for the next one.
    if (shadow_count > 0) begin
      res.value  = shadow_stack[shadow_count-1];
      res.status = shadow_err;
    end else begin
      res.value  = '0;
      res.status = (shadow_err != pfe_pkg::ST_OK) ? shadow_err : pfe_pkg::ST_EMPTY;
    end
    shadow_count   = 0;
    shadow_chained = 1'b0;
    shadow_err     = pfe_pkg::ST_OK;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [7:0] ch, input bit last, input bit typed = 1'b0,
                                  input logic signed [pfe_pkg::WORD_W-1:0] value = '0,
                                  input logic [2:0] status = pfe_pkg::ST_OK);
    char_row_t row;
    row.req.ch     = ch;
    row.req.last   = last;
    row.typed      = typed;
    row.res.value  = value;
    row.res.status = status;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_separator();
    logic [7:0] sep;
    if ($urandom_range(3) != 0) begin
      sep = 8'h20;
    end else begin
      do sep = 8'($urandom_range(255));
      while ((sep >= pfe_pkg::ASCII_ZERO && sep <= pfe_pkg::CH_NINE) ||
             (sep inside {pfe_pkg::CH_PLUS, pfe_pkg::CH_MINUS,
                          pfe_pkg::CH_STAR, pfe_pkg::CH_SLASH}));
    end
    expr_chars.push_back(sep);
  endfunction

  function automatic void add_number();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 2);
    // Numbers must be split from a preceding number.
    if (expr_chars.size() != 0 && expr_chars[$] >= pfe_pkg::ASCII_ZERO &&
        expr_chars[$] <= pfe_pkg::CH_NINE)
      add_separator();
    repeat (len) expr_chars.push_back(pfe_pkg::ASCII_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void add_operator();
    case ($urandom_range(3))
      0: expr_chars.push_back(pfe_pkg::CH_PLUS);
      1: expr_chars.push_back(pfe_pkg::CH_MINUS);
      2: expr_chars.push_back(pfe_pkg::CH_STAR);
      default: expr_chars.push_back(pfe_pkg::CH_SLASH);
    endcase
  endfunction

  // Builds one random expression: mostly well-formed RPN, some deep stacks, some noise.
  function automatic void build_expression();
    int    mode;
    int    nums;
    int    held;
    bit    deep;
    string wrap_case;
    expr_chars.delete();
    mode = $urandom_range(99);
    if (mode < 15) begin
      repeat ($urandom_range(1, 8)) expr_chars.push_back(8'($urandom_range(255)));
      return;
    end
    held = 0;
    if (mode < 22) begin
      // Most negative value divided by minus one.
      wrap_case = "2147483648 0 1-/";
      foreach (wrap_case[i]) expr_chars.push_back(wrap_case[i]);
      held = 1;
    end
    deep = (mode >= 22 && mode < 32);
    nums = deep ? $urandom_range(14, 20) : $urandom_range(1, 6);
    repeat (nums) begin
      add_number();
      held++;
      while (!deep && held >= 2 && $urandom_range(2) == 0) begin
        if ($urandom_range(4) == 0) add_separator();
        add_operator();
        held--;
      end
    end
    while (held > 1) begin
      add_operator();
      held--;
    end
    // Broken sequences: a spare operator that finds too few values.
    if ($urandom_range(9) == 0) add_operator();
    if ($urandom_range(4) == 0) add_separator();
  endfunction

  // Sends one request and records what it should produce once accepted.
  task automatic send_req(input pfe_pkg::pfe_req_t r, input bit typed,
                          input pfe_pkg::pfe_res_t typed_res);
    pfe_pkg::pfe_res_t predicted;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      chr_valid <= 1'b0;
      @(posedge clk);
    end
    chr_valid <= 1'b1;
    chr_data  <= r;
    do @(posedge clk); while (!chr_ready);
    if (rpn_apply_char(r, predicted)) due_results.push_back(typed ? typed_res : predicted);
    sent_cnt++;
  endtask

  // Holds the sender back until every owed result has arrived.
  task automatic wait_idle();
    chr_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: random back-pressure and comparison against the oldest expectation.
  always @(posedge clk) begin
    pfe_pkg::pfe_res_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      if (res_valid && res_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result value=%0d status=%0d", $time,
                   res_data.value, res_data.status);
          fail_cnt++;
        end else begin
          want = due_results.pop_front();
          if (res_data.value !== want.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d", $time,
                     want.value, res_data.value);
            fail_cnt++;
          end
          if (res_data.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     want.status, res_data.status);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Main stimulus.
  initial begin
    pfe_pkg::pfe_req_t req;
    bit                mid_pause_done;
    mid_pause_done = 1'b0;

    // Directed table: empty end, lone operator, division by zero, digit chains,
    // character extremes, every operator, latched error and negative truncation.
    add_row(8'h00,            1'b1, 1'b1, 0, pfe_pkg::ST_EMPTY);
    add_row(pfe_pkg::CH_PLUS, 1'b1, 1'b1, 0, pfe_pkg::ST_UNDERFLOW);
    add_row("7",              1'b0);
    add_row(" ",              1'b0);
    add_row("0",              1'b0);
    add_row(pfe_pkg::CH_SLASH, 1'b1, 1'b1, 0, pfe_pkg::ST_DIVZERO);
    add_row("9",              1'b0);
    add_row("0",              1'b0);
    add_row(8'hFF,            1'b0);
    add_row("4",              1'b0);
    add_row(pfe_pkg::CH_MINUS, 1'b0);
    add_row("3",              1'b0);
    add_row(pfe_pkg::CH_STAR, 1'b0);
    add_row("8",              1'b0);
    add_row(pfe_pkg::CH_PLUS, 1'b1);
    add_row("6",              1'b0);
    add_row(" ",              1'b0);
    add_row(pfe_pkg::CH_MINUS, 1'b0);
    add_row("2",              1'b0);
    add_row(pfe_pkg::CH_SLASH, 1'b1, 1'b1, 3, pfe_pkg::ST_UNDERFLOW);
    add_row("0",              1'b0);
    add_row(8'h80,            1'b0);
    add_row("7",              1'b0);
    add_row(pfe_pkg::CH_MINUS, 1'b0);
    add_row("2",              1'b0);
    add_row(pfe_pkg::CH_SLASH, 1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    wait_idle();

    // Random expressions, with one stretch of steady traffic and one full pause.
    sent_cnt = 0;
    while (sent_cnt < RANDOM_ITEMS) begin
      quiet = (sent_cnt >= 300 && sent_cnt < 500);
      if (!mid_pause_done && sent_cnt >= 700) begin
        wait_idle();
        mid_pause_done = 1'b1;
      end
      build_expression();
      foreach (expr_chars[i]) begin
        req.ch   = expr_chars[i];
        req.last = (i == expr_chars.size() - 1);
        send_req(req, 1'b0, '0);
      end
    end
    quiet = 1'b0;
    wait_idle();

    if (fail_cnt == 0) begin
      $display("postfix_expression_evaluator_unit regression: pass");
    end else begin
      $display("postfix_expression_evaluator_unit regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(5_000_000);
    $display("postfix_expression_evaluator_unit regression: fail");
    $finish;
  end

endmodule
